@@ rtl/bil_pkg.sv @@
// ----------------------------------------------------------------------------
// bil_pkg: shared types for the bounded indexed list
// Request/response payloads, operation and status codes, cell control.
// ----------------------------------------------------------------------------
package bil_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned DataW           = 32;
  localparam int unsigned PosW            = 4;
  localparam int unsigned CountW          = 5;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SET    = 3'd3,
    OP_READ   = 3'd4
  } bil_op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } bil_status_e;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_LOAD   = 2'd1,  // selected cell takes wdata
    MODE_INSERT = 2'd2,  // cells above sel take left neighbor, sel takes wdata
    MODE_REMOVE = 2'd3   // cells at and above sel take right neighbor
  } bil_mode_e;

  typedef struct packed {
    logic [2:0]              op;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] item_value;
  } bil_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    bil_status_e             status;
    logic [CountW-1:0]       count;
  } bil_rsp_t;

  typedef struct packed {
    bil_mode_e               mode;
    logic signed [DataW-1:0] wdata;
  } bil_ctrl_t;

endpackage

@@ rtl/bounded_indexed_list_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_indexed_list_unit: ordered list of signed 32-bit entries
// Append, insert, remove, overwrite and read by position, one request
// per cycle, over a row of shifting cells.
// ----------------------------------------------------------------------------
// Each request taken (start_i high while busy_o is low) is answered: its
// response appears on rsp_o with done_o high for exactly one
// cycle, on the cycle after the request. busy_o never rises, so a new
// request may be issued every cycle; the receiver has no way to stall and
// must take each response on its strobe. All CAPACITY cells shift in
// parallel, so insert and remove take no longer than a read; the
// only serial path is the read mux plus the entry-count compare. The list
// starts empty after reset and entries are defined once written. Only
// positions 0..15 are addressable; outside append, a position at or beyond
// the current count is refused with ST_RANGE, a full list refuses append
// and insert with ST_FULL (full wins over a bad insert position), unknown
// ops are refused with ST_RANGE, and a refused request returns read_value
// 0 and changes nothing.
// ----------------------------------------------------------------------------
module bounded_indexed_list_unit import bil_pkg::*; #(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  bil_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output bil_rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  // common width for comparing the 4-bit position against the count
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  // entry count (control state)
  logic [CntW-1:0] count_d, count_q;

  // response register
  bil_rsp_t rsp_d, rsp_q;
  logic     done_q;

  // cell row
  logic signed [DataW-1:0] cell_val [CAPACITY];
  bil_ctrl_t               ctrl;
  logic [IdxW-1:0]         sel;

  logic            accept;
  logic            full;
  logic            in_range;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic [IdxW-1:0] pos_idx;

  assign accept   = start_i && !busy_o;
  assign pos_ext  = CmpW'(req_i.position);
  assign cnt_ext  = CmpW'(count_q);
  assign in_range = (pos_ext < cnt_ext);
  assign full     = (count_q == CntW'(CAPACITY));
  // only meaningful when in_range, which keeps it below CAPACITY
  assign pos_idx  = IdxW'(pos_ext);

  // Request decode: pick the cell mode and build the response.
  always_comb begin
    ctrl.mode  = MODE_HOLD;
    ctrl.wdata = req_i.item_value;
    sel        = pos_idx;
    count_d    = count_q;
    rsp_d.read_value = '0;
    rsp_d.status     = ST_DONE;

    if (accept) begin
      unique case (req_i.op)
        OP_APPEND: begin
          if (full) begin
            rsp_d.status = ST_FULL;
          end else begin
            // the slot at count is the new tail
            ctrl.mode = MODE_LOAD;
            sel       = IdxW'(count_q);
            count_d   = count_q + 1'b1;
          end
        end
        OP_INSERT: begin
          if (full) begin
            rsp_d.status = ST_FULL;
          end else if (!in_range) begin
            rsp_d.status = ST_RANGE;
          end else begin
            ctrl.mode = MODE_INSERT;
            count_d   = count_q + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!in_range) begin
            rsp_d.status = ST_RANGE;
          end else begin
            ctrl.mode        = MODE_REMOVE;
            rsp_d.read_value = cell_val[pos_idx];
            count_d          = count_q - 1'b1;
          end
        end
        OP_SET: begin
          if (!in_range) rsp_d.status = ST_RANGE;
          else ctrl.mode = MODE_LOAD;
        end
        OP_READ: begin
          if (!in_range) rsp_d.status = ST_RANGE;
          else rsp_d.read_value = cell_val[pos_idx];
        end
        default: rsp_d.status = ST_RANGE;
      endcase
    end

    rsp_d.count = CountW'(count_d);
  end

  // Cell row: cell 0 has no left neighbor, the last cell none on the right.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [DataW-1:0] left_val, right_val;

    if (k == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[k];
    end else begin : g_mid_r
      assign right_val = cell_val[k+1];
    end

    bil_cell #(
      .IdxW (IdxW),
      .Idx  (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .sel_i   (sel),
      .left_i  (left_val),
      .right_i (right_val),
      .value_o (cell_val[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // response payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) rsp_q <= rsp_d;
  end

  // never back-pressure
  assign busy_o = 1'b0;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_rsp_per_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request without response");

  a_no_spurious_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("response without request");

  a_refusal_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_DONE) |->
      (count_q == $past(count_q) && rsp_o.read_value == '0))
    else $error("refused request changed count or returned data");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (count_q == $past(count_q) ||
                count_q == CntW'($past(count_q) + 1'b1) ||
                count_q == CntW'($past(count_q) - 1'b1)))
    else $error("entry count moved by more than one");

endmodule

@@ rtl/bil_cell.sv @@
// ----------------------------------------------------------------------------
// bil_cell: one list slot
// Holds one entry; loads, shifts in from a neighbor or holds per the
// broadcast control and its own position against the select.
// ----------------------------------------------------------------------------
module bil_cell import bil_pkg::*; #(
  parameter int unsigned IdxW = 4,
  parameter int unsigned Idx  = 0
) (
  input  logic                    clk_i,
  input  bil_ctrl_t               ctrl_i,
  input  logic [IdxW-1:0]         sel_i,
  input  logic signed [DataW-1:0] left_i,
  input  logic signed [DataW-1:0] right_i,
  output logic signed [DataW-1:0] value_o
);

  logic signed [DataW-1:0] value_d, value_q;
  logic                    hit, above;

  assign hit   = (sel_i == IdxW'(Idx));
  assign above = (IdxW'(Idx) > sel_i);

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.mode)
      MODE_HOLD: value_d = value_q;
      MODE_LOAD: begin
        if (hit) value_d = ctrl_i.wdata;
      end
      MODE_INSERT: begin
        if (above) value_d = left_i;
        else if (hit) value_d = ctrl_i.wdata;
      end
      MODE_REMOVE: begin
        if (above || hit) value_d = right_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

@@ sim/bounded_indexed_list_unit_tb.sv @@
// ----------------------------------------------------------------------------
// bounded_indexed_list_unit_tb: self-checking bench for the indexed list
// A short directed run through the edge cases is followed by about 1800
// random requests. The random requests come in phases that fill the list,
// drain it or mix the two. A scoreboard keeps its own copy of the list
// and checks every response, field by field, in order.
// ----------------------------------------------------------------------------
module bounded_indexed_list_unit_tb import bil_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Capacity    = DefaultCapacity;
  localparam int unsigned RandomCount = 1800;
  localparam int unsigned MaxReported = 10;

  // Shadow copy of the list. Each accepted request updates it and queues
  // the response the block should give. Responses are checked oldest first.
  class list_scoreboard;
    logic signed [DataW-1:0] cells [Capacity];
    int unsigned             fill;
    bil_rsp_t                pending_q [$];
    int unsigned             mismatches;

    function void note_request(bil_req_t req);
      bil_rsp_t    exp;
      logic        in_range;
      int unsigned i;
      exp.read_value = '0;
      exp.status     = ST_DONE;
      in_range       = req.position < fill;
      case (req.op)
        OP_APPEND: begin
          if (fill >= Capacity) begin
            exp.status = ST_FULL;
          end else begin
            cells[fill] = req.item_value;
            fill++;
          end
        end
        OP_INSERT: begin
          // full wins over a bad position
          if (fill >= Capacity) begin
            exp.status = ST_FULL;
          end else if (!in_range) begin
            exp.status = ST_RANGE;
          end else begin
            for (i = fill; i > req.position; i--) cells[i] = cells[i-1];
            cells[req.position] = req.item_value;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (!in_range) begin
            exp.status = ST_RANGE;
          end else begin
            exp.read_value = cells[req.position];
            for (i = req.position; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end
        end
        OP_SET: begin
          if (!in_range) exp.status = ST_RANGE;
          else cells[req.position] = req.item_value;
        end
        OP_READ: begin
          if (!in_range) exp.status = ST_RANGE;
          else exp.read_value = cells[req.position];
        end
        default: begin
          exp.status = ST_RANGE;
        end
      endcase
      exp.count = CountW'(fill);
      pending_q.push_back(exp);
    endfunction

    function void check_response(bil_rsp_t got);
      bil_rsp_t exp;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("%0t: response with none pending: value %h status %0d count %0d",
                   $realtime, got.read_value, got.status, got.count);
        return;
      end
      exp = pending_q.pop_front();
      if (got.read_value !== exp.read_value || got.status !== exp.status ||
          got.count !== exp.count) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("%0t: mismatch: value %h/%h status %0d/%0d count %0d/%0d (exp/got)",
                   $realtime, exp.read_value, got.read_value, exp.status, got.status,
                   exp.count, got.count);
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start_i;
  bil_req_t req_i;
  logic     busy_o;
  logic     done_o;
  bil_rsp_t rsp_o;

  list_scoreboard sb = new();

  // sender burst state: requests left in this burst
  int unsigned burst_left = 0;

  bounded_indexed_list_unit #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Response monitor. done_o marks a response for one cycle only and
  // cannot be held off, so every strobe is checked at its closing edge.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_response(rsp_o);
  end

  function automatic bil_req_t make_req(logic [2:0] op, logic [PosW-1:0] pos,
                                        logic signed [DataW-1:0] value);
    bil_req_t r;
    r.op         = op;
    r.position   = pos;
    r.item_value = value;
    return r;
  endfunction

  // Data mix: the extremes and small numbers show up often, the rest is
  // spread over the full 32 bits.
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '1;
      3:       return '0;
      4:       return DataW'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  // Idle cycles: start_i low, junk on the payload that must be ignored.
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i = 1'b0;
      req_i   = bil_req_t'($bits(bil_req_t)'({$urandom, $urandom}));
    end
  endtask

  // Drive one request. Requests go out in bursts. A burst keeps start_i
  // high back to back, and random gaps fall between bursts. A zero gap
  // joins two bursts into a longer stretch with no idling.
  task automatic issue_request(bil_req_t req);
    if (burst_left == 0) begin
      if ($urandom_range(3) == 0) idle_cycles(0);
      else idle_cycles($urandom_range(8, 1));
      burst_left = $urandom_range(30, 1);
    end
    burst_left--;
    @(negedge clk_i);
    start_i = 1'b1;
    req_i   = req;
    // accepted at the first rising edge with busy_o low
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_request(req);
  endtask

  initial begin
    int unsigned      sent;
    int unsigned      phase_len;
    int unsigned      phase_kind;
    int unsigned      roll;
    int unsigned      fill;
    logic [2:0]       op;
    logic [PosW-1:0]  pos;
    bil_req_t         req;

    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed: empty list, extremes, shifting, bounds, unknown ops ----
    issue_request(make_req(OP_READ,   4'd0,  32'h1111_1111));  // empty list
    issue_request(make_req(OP_REMOVE, 4'd0,  32'h0));
    issue_request(make_req(OP_SET,    4'd3,  32'h2222_2222));
    issue_request(make_req(OP_INSERT, 4'd0,  32'h3333_3333));  // never adds at end
    issue_request(make_req(OP_APPEND, 4'd9,  32'h7FFF_FFFF));
    issue_request(make_req(OP_REMOVE, 4'd0,  32'h0));          // last entry goes
    issue_request(make_req(OP_APPEND, 4'd0,  32'h8000_0000));
    issue_request(make_req(OP_APPEND, 4'd15, 32'hFFFF_FFFF));
    issue_request(make_req(OP_APPEND, 4'd0,  32'h0));
    issue_request(make_req(OP_INSERT, 4'd0,  32'h1234_5678));  // at the head
    issue_request(make_req(OP_INSERT, 4'd3,  32'hA5A5_A5A5));  // before the tail
    issue_request(make_req(OP_INSERT, 4'd5,  32'h4444_4444));  // position == count
    issue_request(make_req(OP_SET,    4'd1,  32'h5A5A_5A5A));
    issue_request(make_req(OP_READ,   4'd0,  32'h0));
    issue_request(make_req(OP_READ,   4'd4,  32'h0));
    issue_request(make_req(OP_READ,   4'd15, 32'h0));
    issue_request(make_req(OP_REMOVE, 4'd2,  32'h0));          // middle
    issue_request(make_req(OP_REMOVE, 4'd3,  32'h0));          // tail
    issue_request(make_req(3'd5,      4'd0,  32'hDEAD_BEEF));  // unknown ops
    issue_request(make_req(3'd6,      4'd1,  32'h0));
    issue_request(make_req(3'd7,      4'd15, 32'hFFFF_FFFF));
    issue_request(make_req(OP_SET,    4'd15, 32'h6666_6666));

    // ---- random: phases that fill, drain or mix ----
    // Most positions fall inside the list (often at its ends), so the
    // shifting paths get exercised. The rest: the count, or any of 0..15.
    sent = 0;
    while (sent < RandomCount) begin
      phase_kind = $urandom_range(2);
      phase_len  = $urandom_range(40, 5);
      repeat (phase_len) begin
        fill = sb.fill;
        roll = $urandom_range(99);
        case (phase_kind)
          0: op = roll < 35 ? OP_APPEND : roll < 65 ? OP_INSERT : roll < 75 ? OP_REMOVE :
                  roll < 86 ? OP_SET : roll < 98 ? OP_READ : 3'($urandom_range(7, 5));
          1: op = roll < 10 ? OP_APPEND : roll < 20 ? OP_INSERT : roll < 65 ? OP_REMOVE :
                  roll < 80 ? OP_SET : roll < 98 ? OP_READ : 3'($urandom_range(7, 5));
          default:
             op = roll < 20 ? OP_APPEND : roll < 40 ? OP_INSERT : roll < 60 ? OP_REMOVE :
                  roll < 78 ? OP_SET : roll < 97 ? OP_READ : 3'($urandom_range(7, 5));
        endcase
        roll = $urandom_range(99);
        if (fill > 0 && roll < 60) pos = PosW'($urandom_range(fill - 1));
        else if (fill > 0 && roll < 72) pos = '0;
        else if (fill > 0 && roll < 84) pos = PosW'(fill - 1);
        else if (roll < 90) pos = PosW'(fill);
        else pos = PosW'($urandom_range(15));
        req = make_req(op, pos, pick_value());
        issue_request(req);
        sent++;
      end
    end

    idle_cycles(1);
    // drain: wait until every pending response has been checked
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("bounded_indexed_list_unit_tb: PASS");
    end else begin
      $display("bounded_indexed_list_unit_tb: FAIL");
    end
    $finish;
  end

  // A correct run takes well under 0.2 ms. Give it 2 ms.
  initial begin
    #2_000_000;
    $display("bounded_indexed_list_unit_tb: FAIL");
    $finish;
  end

endmodule
